// ===== rtl/dlmtf_pkg.sv =====
// Shared types, widths and constants for the diffraction-limited MTF pipeline.
// Used by the division, square-root and CORDIC cells and by the top level.
package dlmtf_pkg;

    localparam int FREQ_W       = 32;
    localparam int CUT_W        = 31;
    localparam int MTF_W        = 18;
    localparam int GQ_W         = 30;   // Q0.30 normalized frequency
    localparam int SQ_W         = 31;   // Q0.30 complement root, up to 1.0
    localparam int RAD_W        = 61;   // radicand 2^60 - gq^2
    localparam int XY_W         = 33;
    localparam int Z_W          = 33;
    localparam int DIV_STEPS    = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int CORDIC_STEPS = 31;
    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;

    typedef struct packed {
        logic vld;
        logic neg;
        logic zero;   // at or past the band edge, or zero cutoff: result forced to 0
    } side_t;

    typedef logic signed [XY_W-1:0] xy_t;

    function automatic logic [Z_W-1:0] atan_entry(input int idx);
        logic [Z_W-1:0] r;
        case (idx)
            0:  r = 33'd843314856;
            1:  r = 33'd497837829;
            2:  r = 33'd263043836;
            3:  r = 33'd133525158;
            4:  r = 33'd67021686;
            5:  r = 33'd33543515;
            6:  r = 33'd16775850;
            7:  r = 33'd8388437;
            8:  r = 33'd4194282;
            9:  r = 33'd2097149;
            10: r = 33'd1048575;
            11: r = 33'd524287;
            12: r = 33'd262143;
            13: r = 33'd131071;
            14: r = 33'd65535;
            15: r = 33'd32767;
            16: r = 33'd16383;
            17: r = 33'd8191;
            18: r = 33'd4095;
            19: r = 33'd2047;
            20: r = 33'd1023;
            21: r = 33'd511;
            22: r = 33'd255;
            23: r = 33'd127;
            24: r = 33'd63;
            25: r = 33'd31;
            26: r = 33'd15;
            27: r = 33'd8;
            28: r = 33'd4;
            29: r = 33'd2;
            30: r = 33'd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Shift toward zero: negative values shift their magnitude.
    function automatic xy_t shr_sym(input xy_t v, input int s);
        xy_t m;
        m = -v;
        return v[XY_W-1] ? -(xy_t'(m >> s)) : xy_t'(v >> s);
    endfunction

endpackage

// ===== rtl/dlmtf_div_cell.sv =====
// One restoring-division step: shifts the remainder, subtracts the cutoff if it fits.
// Depends on dlmtf_pkg.
module dlmtf_div_cell
    import dlmtf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [CUT_W-1:0] cutoff,
    input  side_t            side_in,
    input  logic [CUT_W-1:0] rem_in,
    input  logic [GQ_W-1:0]  quo_in,
    output side_t            side_reg,
    output logic [CUT_W-1:0] rem_reg,
    output logic [GQ_W-1:0]  quo_reg
);

    logic [CUT_W:0]   shifted;
    logic             take;
    logic [CUT_W:0]   diff;
    logic [CUT_W-1:0] rem_next;
    logic [GQ_W-1:0]  quo_next;

    always_comb
    begin
        shifted  = {rem_in, 1'b0};
        take     = shifted >= {1'b0, cutoff};
        diff     = shifted - {1'b0, cutoff};
        rem_next = take ? diff[CUT_W-1:0] : shifted[CUT_W-1:0];
        quo_next = {quo_in[GQ_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

// ===== rtl/dlmtf_sqrt_cell.sv =====
// One digit of an integer square root; BIT is the root bit this cell decides.
// Depends on dlmtf_pkg.
module dlmtf_sqrt_cell
    import dlmtf_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  side_t            side_in,
    input  logic [RAD_W-1:0] rem_in,
    input  logic [SQ_W-1:0]  root_in,
    input  logic [GQ_W-1:0]  gq_in,
    output side_t            side_reg,
    output logic [RAD_W-1:0] rem_reg,
    output logic [SQ_W-1:0]  root_reg,
    output logic [GQ_W-1:0]  gq_reg
);

    logic [RAD_W:0]   trial;
    logic             take;
    logic [RAD_W:0]   diff;
    logic [RAD_W-1:0] rem_next;
    logic [SQ_W-1:0]  root_next;

    // (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b)
    always_comb
    begin
        trial     = ((RAD_W+1)'(root_in) << (BIT + 1)) + ((RAD_W+1)'(1) << (2 * BIT));
        take      = {1'b0, rem_in} >= trial;
        diff      = {1'b0, rem_in} - trial;
        rem_next  = take ? diff[RAD_W-1:0] : rem_in;
        root_next = take ? (root_in | (SQ_W'(1) << BIT)) : root_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            gq_reg   <= gq_in;
        end
    end

endmodule

// ===== rtl/dlmtf_cordic_cell.sv =====
// One CORDIC vectoring rotation; STEP selects shift and arctangent entry.
// Depends on dlmtf_pkg.
module dlmtf_cordic_cell
    import dlmtf_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  side_t           side_in,
    input  xy_t             x_in,
    input  xy_t             y_in,
    input  logic [Z_W-1:0]  z_in,
    input  logic [SQ_W-1:0] gs_in,
    output side_t           side_reg,
    output xy_t             x_reg,
    output xy_t             y_reg,
    output logic [Z_W-1:0]  z_reg,
    output logic [SQ_W-1:0] gs_reg
);

    localparam logic [Z_W-1:0] ANGLE = atan_entry(STEP);

    xy_t            dx;
    xy_t            dy;
    xy_t            x_next;
    xy_t            y_next;
    logic [Z_W-1:0] z_next;

    always_comb
    begin
        dx = shr_sym(y_in, STEP);
        dy = shr_sym(x_in, STEP);
        if (!y_in[XY_W-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            gs_reg <= gs_in;
        end
    end

endmodule

// ===== rtl/diffraction_limited_mtf.sv =====
// Top level of the diffraction-limited MTF pipeline (circular aperture).
// Depends on dlmtf_pkg, dlmtf_div_cell, dlmtf_sqrt_cell, dlmtf_cordic_cell.
//
//  channel | signals                                  | payload
//  --------+------------------------------------------+---------------------------
//  input   | in_valid / in_ready                      | frequency, signed Q16.16
//  output  | out_valid / out_ready                    | mtf_value, unsigned Q2.F
//  config  | cfg_valid / cfg_ready (always ready)     | cutoff_frequency, unsigned Q15.16
//
// One transfer per cycle in each direction unless stalled. Stages in order: input register,
// 30 division cells, squaring, 31 root cells, g*sqrt product, 31 CORDIC cells,
// the 2/pi product and the output register.
// Reset clears only the side bits and output valid, and sets the cutoff register to 1.0; no clearing pass.
// The whole chain advances unless its last stage holds a result and the output
// register is full and not being taken; bubbles do not stall input.
module diffraction_limited_mtf
    import dlmtf_pkg::*;
#(
    parameter int RESULT_FRACTION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [FREQ_W-1:0] frequency,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [MTF_W-1:0]         mtf_value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CUT_W-1:0]         cutoff_frequency
);

    localparam int F = RESULT_FRACTION_BITS;
    localparam logic [63:0] ROUND_HALF = 64'd1 << (61 - F);
    localparam logic [63:0] SAT_LIMIT  = 64'd2 << F;
    localparam logic [63:0] ONE_Q63    = 64'd1 << 63;

    logic [CUT_W-1:0] cutoff_reg;
    logic             adv;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CUT_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            cutoff_reg <= cutoff_frequency;
        end
    end

    // ---------------- input stage: magnitude and band check ----------------
    side_t            in_side_reg;
    logic [CUT_W-1:0] in_rem_reg;
    logic [FREQ_W-1:0] mag;
    side_t            in_side_next;

    always_comb
    begin
        mag               = frequency[FREQ_W-1] ? FREQ_W'(-frequency) : FREQ_W'(frequency);
        in_side_next.vld  = in_valid;
        in_side_next.neg  = frequency[FREQ_W-1];
        in_side_next.zero = (cutoff_reg == '0) || (mag >= {1'b0, cutoff_reg});
    end

    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_side_reg <= '0;
        end
        else if (adv)
        begin
            in_side_reg <= in_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_rem_reg <= mag[CUT_W-1:0];
        end
    end

    // ---------------- division chain: gq = |f| * 2^30 / cutoff ----------------
    side_t            div_side [0:DIV_STEPS];
    logic [CUT_W-1:0] div_rem  [0:DIV_STEPS];
    logic [GQ_W-1:0]  div_quo  [0:DIV_STEPS];

    assign div_side[0] = in_side_reg;
    assign div_rem[0]  = in_rem_reg;
    assign div_quo[0]  = '0;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        dlmtf_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .cutoff   (cutoff_reg),
            .side_in  (div_side[k]),
            .rem_in   (div_rem[k]),
            .quo_in   (div_quo[k]),
            .side_reg (div_side[k+1]),
            .rem_reg  (div_rem[k+1]),
            .quo_reg  (div_quo[k+1])
        );
    end

    // ---------------- radicand 2^60 - gq^2 ----------------
    side_t            sqr_side_reg;
    logic [RAD_W-1:0] sqr_rad_reg;
    logic [GQ_W-1:0]  sqr_gq_reg;
    logic [59:0]      gq_square;

    assign gq_square = div_quo[DIV_STEPS] * div_quo[DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqr_side_reg <= '0;
        end
        else if (adv)
        begin
            sqr_side_reg <= div_side[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqr_rad_reg <= (RAD_W'(1) << 60) - RAD_W'(gq_square);
            sqr_gq_reg  <= div_quo[DIV_STEPS];
        end
    end

    // ---------------- square-root chain ----------------
    side_t            rt_side [0:SQRT_STEPS];
    logic [RAD_W-1:0] rt_rem  [0:SQRT_STEPS];
    logic [SQ_W-1:0]  rt_root [0:SQRT_STEPS];
    logic [GQ_W-1:0]  rt_gq   [0:SQRT_STEPS];

    assign rt_side[0] = sqr_side_reg;
    assign rt_rem[0]  = sqr_rad_reg;
    assign rt_root[0] = '0;
    assign rt_gq[0]   = sqr_gq_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        dlmtf_sqrt_cell #(
            .BIT (SQRT_STEPS - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .side_in  (rt_side[k]),
            .rem_in   (rt_rem[k]),
            .root_in  (rt_root[k]),
            .gq_in    (rt_gq[k]),
            .side_reg (rt_side[k+1]),
            .rem_reg  (rt_rem[k+1]),
            .root_reg (rt_root[k+1]),
            .gq_reg   (rt_gq[k+1])
        );
    end

    // ---------------- g * sqrt(1-g^2) ----------------
    side_t           gs_side_reg;
    logic [SQ_W-1:0] gs_reg;
    logic [GQ_W-1:0] gs_gq_reg;
    logic [SQ_W-1:0] gs_sq_reg;
    logic [60:0]     gs_prod;

    assign gs_prod = rt_gq[SQRT_STEPS] * rt_root[SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_side_reg <= '0;
        end
        else if (adv)
        begin
            gs_side_reg <= rt_side[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gs_reg    <= gs_prod[60:30];
            gs_gq_reg <= rt_gq[SQRT_STEPS];
            gs_sq_reg <= rt_root[SQRT_STEPS];
        end
    end

    // ---------------- CORDIC chain: z -> acos(g) ----------------
    side_t           cd_side [0:CORDIC_STEPS];
    xy_t             cd_x    [0:CORDIC_STEPS];
    xy_t             cd_y    [0:CORDIC_STEPS];
    logic [Z_W-1:0]  cd_z    [0:CORDIC_STEPS];
    logic [SQ_W-1:0] cd_gs   [0:CORDIC_STEPS];

    assign cd_side[0] = gs_side_reg;
    assign cd_x[0]    = xy_t'(gs_gq_reg);
    assign cd_y[0]    = xy_t'(gs_sq_reg);
    assign cd_z[0]    = '0;
    assign cd_gs[0]   = gs_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        dlmtf_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .side_in  (cd_side[k]),
            .x_in     (cd_x[k]),
            .y_in     (cd_y[k]),
            .z_in     (cd_z[k]),
            .gs_in    (cd_gs[k]),
            .side_reg (cd_side[k+1]),
            .x_reg    (cd_x[k+1]),
            .y_reg    (cd_y[k+1]),
            .z_reg    (cd_z[k+1]),
            .gs_reg   (cd_gs[k+1])
        );
    end

    // ---------------- (acos g - g*sqrt) * 2/pi ----------------
    side_t          h_side_reg;
    logic [62:0]    h_reg;
    logic [Z_W-1:0] d_raw;
    logic [30:0]    d_clamped;

    always_comb
    begin
        d_raw     = cd_z[CORDIC_STEPS] - Z_W'(cd_gs[CORDIC_STEPS]);
        d_clamped = d_raw[Z_W-1] ? '0 : d_raw[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_side_reg <= '0;
        end
        else if (adv)
        begin
            h_side_reg <= cd_side[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_reg <= d_clamped * TWO_OVER_PI_Q32;
        end
    end

    // ---------------- mirror, round, saturate; output register ----------------
    logic [63:0]      v_full;
    logic [63:0]      v_round;
    logic [MTF_W-1:0] mtf_next;
    logic             out_valid_reg;
    logic [MTF_W-1:0] mtf_reg;

    always_comb
    begin
        v_full   = h_side_reg.neg ? (ONE_Q63 - {1'b0, h_reg}) : {1'b0, h_reg};
        v_round  = (v_full + ROUND_HALF) >> (62 - F);
        if (v_round > SAT_LIMIT)
        begin
            v_round = SAT_LIMIT;
        end
        mtf_next = h_side_reg.zero ? '0 : v_round[MTF_W-1:0];
    end

    // Stall only when a finished result has nowhere to go.
    assign adv = !(h_side_reg.vld && out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && h_side_reg.vld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && h_side_reg.vld)
        begin
            mtf_reg <= mtf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign mtf_value = mtf_reg;

    // ---------------- checks ----------------
    a_band_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
        adv && h_side_reg.vld && h_side_reg.zero |=> mtf_value == '0)
        else $error("band-edge sample gave a nonzero result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !out_ready && h_side_reg.vld)
        else $error("input stalled without a blocked result");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ready && !h_side_reg.vld |=> !out_valid_reg)
        else $error("output stayed valid after its transfer with nothing behind it");

endmodule

// ===== dv/diffraction_limited_mtf_checker.sv =====
`timescale 1ns / 1ps
// Checker for the diffraction-limited MTF block: watches the three channels,
// predicts each result in fixed point and compares. Depends on dlmtf_pkg.
module diffraction_limited_mtf_checker
    import dlmtf_pkg::*;
#(
    parameter int RESULT_FRACTION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic signed [FREQ_W-1:0] frequency,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [MTF_W-1:0]         mtf_value,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CUT_W-1:0]         cutoff_frequency,
    output int                       errors,
    output int                       pending,
    output int                       results_seen
);

    localparam longint unsigned K_2_OVER_PI = 64'd2734261102;

    logic [CUT_W-1:0] cutoff_q;
    logic [MTF_W-1:0] mtf_expected_q[$];

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int i = 30; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic longint toward_zero(input longint v, input int s);
        return (v < 0) ? -((-v) >>> s) : (v >>> s);
    endfunction

    function automatic logic [MTF_W-1:0] mtf_of(input logic signed [FREQ_W-1:0] f,
                                                 input logic [CUT_W-1:0] cut);
        longint unsigned mag, gq, sq, h, v, lim;
        longint x, y, z, nx, d;
        logic neg;
        neg = f[FREQ_W-1];
        mag = neg ? longint'(-longint'(f)) : longint'(f);
        if (cut == 0 || mag >= cut)
            return '0;
        gq = (mag << 30) / cut;
        sq = root_floor((64'd1 << 60) - gq * gq);
        x = gq;
        y = sq;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            nx = (y >= 0) ? x + toward_zero(y, i) : x - toward_zero(y, i);
            if (y >= 0)
            begin
                y = y - toward_zero(x, i);
                z = z + longint'(atan_entry(i));
            end
            else
            begin
                y = y + toward_zero(x, i);
                z = z - longint'(atan_entry(i));
            end
            x = nx;
        end
        d = z - longint'((gq * sq) >> 30);
        if (d < 0)
            d = 0;
        h = longint'(d) * K_2_OVER_PI;
        if (h > (64'd1 << 63))
            h = 64'd1 << 63;
        v = neg ? ((64'd1 << 63) - h) : h;
        v = (v + (64'd1 << (61 - RESULT_FRACTION_BITS))) >> (62 - RESULT_FRACTION_BITS);
        lim = 64'd2 << RESULT_FRACTION_BITS;
        if (v > lim)
            v = lim;
        return v[MTF_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    assign pending = mtf_expected_q.size();

    initial
    begin
        errors = 0;
        results_seen = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_q = 31'd65536;
            mtf_expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cutoff_q = cutoff_frequency;
            if (in_valid && in_ready)
                mtf_expected_q.push_back(mtf_of(frequency, cutoff_q));
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (mtf_expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d", mtf_value));
                else if (mtf_value !== mtf_expected_q[0])
                    report_mismatch($sformatf("mtf_value %0d, expected %0d",
                                              mtf_value, mtf_expected_q[0]));
                if (mtf_expected_q.size() != 0)
                    void'(mtf_expected_q.pop_front());
            end
        end
    end

endmodule

// ===== dv/diffraction_limited_mtf_tb.sv =====
`timescale 1ns / 1ps
// Top of the diffraction-limited MTF testbench: clock, reset, stimulus, verdict.
// Depends on dlmtf_pkg, diffraction_limited_mtf and diffraction_limited_mtf_checker.
module diffraction_limited_mtf_tb;
    import dlmtf_pkg::*;

    localparam int LATENCY     = 97;
    localparam int DRAIN_WAIT  = LATENCY + 20;
    localparam int QUIET_LIMIT = 5000;     // cycles with no transfer at all
    localparam int HOLD_CYCLES = 400;      // long receiver hold-off
    localparam int PER_MIX     = 32;       // random samples per handshake mix

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [FREQ_W-1:0] frequency;
    logic                     out_valid;
    logic                     out_ready;
    logic [MTF_W-1:0]         mtf_value;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CUT_W-1:0]         cutoff_frequency;

    int errors, pending, results_seen;
    int send_idle_pct, recv_stall_pct;
    bit recv_hold;
    int quiet_cycles;
    logic [CUT_W-1:0] cutoff_now;
    logic [CUT_W-1:0] cutoff_list[5];

    diffraction_limited_mtf i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .frequency        (frequency),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mtf_value        (mtf_value),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cutoff_frequency (cutoff_frequency)
    );

    diffraction_limited_mtf_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .frequency        (frequency),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mtf_value        (mtf_value),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cutoff_frequency (cutoff_frequency),
        .errors           (errors),
        .pending          (pending),
        .results_seen     (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Receiver: random stalls at the set rate, plus a hard hold while recv_hold.
    always @(negedge clk)
        out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: any transfer on any channel resets the quiet counter.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: %0d cycles without a transfer", QUIET_LIMIT);
            $display("diffraction_limited_mtf_tb: FAIL");
            $finish;
        end
    end

    // One input transfer; idle cycles come first so valid never drops mid-item.
    task automatic send_sample(input logic signed [FREQ_W-1:0] f);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        frequency <= f;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Register writes only once the pipe has emptied out.
    task automatic write_cutoff(input logic [CUT_W-1:0] c);
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        cfg_valid        <= 1'b1;
        cutoff_frequency <= c;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cutoff_now = c;
    endtask

    // Mostly inside the passband, where the CORDIC path does real work.
    function automatic logic signed [FREQ_W-1:0] random_sample();
        logic [31:0] m;
        if ($urandom_range(99) < 20 || cutoff_now == 0)
            return $urandom;
        m = $urandom_range(cutoff_now - 1, 0);
        return $urandom_range(1) ? -$signed(m) : $signed(m);
    endfunction

    task automatic directed_samples();
        logic signed [FREQ_W-1:0] c;
        c = $signed({1'b0, cutoff_now});
        send_sample(0);
        send_sample(1);
        send_sample(-1);
        send_sample(c - 1);
        send_sample(-(c - 1));
        send_sample(c);
        send_sample(-c);
        send_sample(c >>> 1);
        send_sample(-(c >>> 1));
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh5555_5555);
        send_sample(32'shAAAA_AAAA);
        end_burst();
    endtask

    task automatic hold_receiver();
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold = 1'b0;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        frequency        = '0;
        cfg_valid        = 1'b0;
        cutoff_frequency = '0;
        out_ready        = 1'b0;
        recv_hold        = 1'b0;
        quiet_cycles     = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        cutoff_now       = 31'd65536;
        // reset value first, then the extremes, a zero register and a wide one
        cutoff_list = '{31'd65536, 31'd1, 31'h7FFF_FFFF, 31'd0, 31'd3_000_000};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (cutoff_list[k])
        begin
            if (k != 0)
                write_cutoff(cutoff_list[k]);
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            directed_samples();
            // handshake mixes: none, sender idle, receiver stall, both
            for (int mix = 0; mix < 4; mix++)
            begin
                send_idle_pct  = (mix == 1) ? 70 : (mix == 3) ? 29 : 0;
                recv_stall_pct = (mix == 2) ? 70 : (mix == 3) ? 29 : 0;
                if (mix == 0 && k == 0)
                begin
                    // back pressure: receiver frozen while the sender keeps pushing
                    fork
                        hold_receiver();
                        for (int n = 0; n < HOLD_CYCLES; n++)
                            send_sample(random_sample());
                    join
                end
                for (int n = 0; n < PER_MIX; n++)
                    send_sample(random_sample());
                end_burst();
            end
        end

        recv_stall_pct = 0;
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("covered %0d results over %0d cutoff settings, four handshake mixes",
                 results_seen, 5);
        $display("and one long receiver hold-off; %0d mismatches", errors);
        if (errors == 0 && pending == 0)
            $display("diffraction_limited_mtf_tb: PASS");
        else
            $display("diffraction_limited_mtf_tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dlmtf_pkg.sv
rtl/dlmtf_div_cell.sv
rtl/dlmtf_sqrt_cell.sv
rtl/dlmtf_cordic_cell.sv
rtl/diffraction_limited_mtf.sv
dv/diffraction_limited_mtf_checker.sv
dv/diffraction_limited_mtf_tb.sv
